// File: design/llf_pkg.sv
package llf_pkg;

  localparam int ACTION_W   = 2;
  localparam int ROW_W      = 6;
  localparam int IN_IDX_W   = 8;
  localparam int VALUE_W    = 16;
  localparam int RESULT_W   = 32;
  localparam int ACC_W      = 40;
  localparam int PROD_W     = 32;
  localparam int COL_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int IN_CH_W    = 9;
  localparam int OUT_CH_W   = 7;
  localparam int QUEUE_AW   = 2;

  typedef logic [ROW_W-1:0]             row_t;
  typedef logic [COL_W-1:0]             col_t;
  typedef logic signed [VALUE_W-1:0]    value_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic signed [RESULT_W-1:0]   result_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WEIGHT = 2'd0,
    ACT_BIAS   = 2'd1,
    ACT_DATA   = 2'd2
  } action_t;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNELS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_BIAS     = 2'd2;

  localparam logic [IN_CH_W-1:0]  IN_CHANNELS_RST  = 9'd256;
  localparam logic [OUT_CH_W-1:0] OUT_CHANNELS_RST = 7'd64;

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_BIAS   = 2'd1,
    CMD_DATA   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    row_t      row;
    col_t      col;
    value_t    value;
    logic      first;
    logic      last;
  } cmd_t;

  typedef struct packed {
    logic [IN_CH_W-1:0]  in_channels;
    logic [OUT_CH_W-1:0] out_channels;
    logic                use_bias;
  } cfg_t;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SWEEP    = 6'b000010,
    ST_DRAIN    = 6'b000100,
    ST_EMIT_RD  = 6'b001000,
    ST_EMIT_LD  = 6'b010000,
    ST_EMIT_OUT = 6'b100000
  } back_state_t;

endpackage

// File: design/llf_in_if.sv
interface llf_in_if;
  logic                            valid;
  logic                            ready;
  logic [llf_pkg::ACTION_W-1:0]    action;
  logic [llf_pkg::ROW_W-1:0]       out_index;
  logic [llf_pkg::IN_IDX_W-1:0]    in_index;
  logic signed [llf_pkg::VALUE_W-1:0] value;

  modport source (output valid, action, out_index, in_index, value, input ready);
  modport sink   (input valid, action, out_index, in_index, value, output ready);
endinterface

// File: design/llf_out_if.sv
interface llf_out_if;
  logic                               valid;
  logic                               ready;
  logic [llf_pkg::ROW_W-1:0]          channel;
  logic signed [llf_pkg::RESULT_W-1:0] result_value;
  logic                               last_of_row;

  modport source (output valid, channel, result_value, last_of_row, input ready);
  modport sink   (input valid, channel, result_value, last_of_row, output ready);
endinterface

// File: design/llf_front.sv
module llf_front #(
  parameter int MAX_IN_CHANNELS  = 256,
  parameter int MAX_OUT_CHANNELS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  llf_pkg::cfg_t   cfg,
  llf_in_if.sink          in_item,
  input  logic            queue_full,
  output logic            push,
  output llf_pkg::cmd_t   push_data
);

  localparam int IW = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
  localparam int PW = $clog2(MAX_IN_CHANNELS + 1);
  localparam int CW = (PW > llf_pkg::IN_CH_W) ? PW : llf_pkg::IN_CH_W;

  logic [IW-1:0] pos_r;
  logic [IW-1:0] pos_nxt;
  logic [CW-1:0] cfg_in;
  logic [CW-1:0] n_in;
  logic [CW-1:0] pos_inc;
  logic          accept;
  logic          keep;
  logic          row_last;
  logic          row_ok;
  logic          col_ok;

  assign in_item.ready = !queue_full;
  assign accept        = in_item.valid && in_item.ready;

  assign cfg_in = CW'(cfg.in_channels);
  assign n_in   = (cfg_in == '0) ? CW'(1) :
                  (cfg_in > CW'(MAX_IN_CHANNELS)) ? CW'(MAX_IN_CHANNELS) : cfg_in;

  assign pos_inc  = CW'(pos_r) + CW'(1);
  assign row_last = (pos_inc >= n_in);

  assign row_ok = (int'(in_item.out_index) < MAX_OUT_CHANNELS);
  assign col_ok = (int'(in_item.in_index) < MAX_IN_CHANNELS);

  always_comb begin
    keep            = 1'b0;
    pos_nxt         = pos_r;
    push_data.kind  = llf_pkg::CMD_DATA;
    push_data.row   = in_item.out_index;
    push_data.col   = llf_pkg::col_t'(in_item.in_index);
    push_data.value = in_item.value;
    push_data.first = 1'b0;
    push_data.last  = 1'b0;
    case (in_item.action)
      llf_pkg::ACT_WEIGHT: begin
        keep           = row_ok && col_ok;
        push_data.kind = llf_pkg::CMD_WEIGHT;
      end
      llf_pkg::ACT_BIAS: begin
        keep           = row_ok;
        push_data.kind = llf_pkg::CMD_BIAS;
      end
      llf_pkg::ACT_DATA: begin
        keep            = 1'b1;
        push_data.kind  = llf_pkg::CMD_DATA;
        push_data.col   = llf_pkg::col_t'(pos_r);
        push_data.first = (pos_r == '0);
        push_data.last  = row_last;
        pos_nxt         = row_last ? '0 : pos_inc[IW-1:0];
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = accept && keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// File: design/llf_queue.sv
module llf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  llf_pkg::cmd_t push_data,
  output logic          full,
  output logic          q_valid,
  input  logic          pop,
  output llf_pkg::cmd_t q_data
);

  localparam int DEPTH = 2 ** llf_pkg::QUEUE_AW;

  llf_pkg::cmd_t                 mem_r [DEPTH];
  logic [llf_pkg::QUEUE_AW-1:0]  wr_ptr_r;
  logic [llf_pkg::QUEUE_AW-1:0]  rd_ptr_r;
  logic [llf_pkg::QUEUE_AW:0]    count_r;
  logic                          do_push;
  logic                          do_pop;

  assign full    = (count_r == (llf_pkg::QUEUE_AW + 1)'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: design/llf_back.sv
module llf_back #(
  parameter int MAX_IN_CHANNELS  = 256,
  parameter int MAX_OUT_CHANNELS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  llf_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  llf_pkg::cmd_t q_data,
  output logic          q_pop,
  llf_out_if.source     out_item
);

  localparam int IW     = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
  localparam int OW     = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int AW     = OW + IW;
  localparam int WDEPTH = 2 ** AW;

  logic [llf_pkg::VALUE_W-1:0] w_mem [WDEPTH];
  logic [llf_pkg::VALUE_W-1:0] b_mem [MAX_OUT_CHANNELS];
  llf_pkg::acc_t               a_mem [MAX_OUT_CHANNELS];

  llf_pkg::back_state_t state_r;
  llf_pkg::back_state_t state_nxt;
  llf_pkg::cmd_t        cmd_r;
  logic [OW-1:0]        o_r;

  logic signed [llf_pkg::VALUE_W-1:0] w_q_r;
  logic signed [llf_pkg::VALUE_W-1:0] b_q_r;
  llf_pkg::acc_t                      a_q_r;

  logic                              s1_v_r;
  logic [OW-1:0]                     s1_ch_r;
  logic                              s2_v_r;
  logic [OW-1:0]                     s2_ch_r;
  logic signed [llf_pkg::PROD_W-1:0] prod_r;
  llf_pkg::acc_t                     base_r;

  logic signed [llf_pkg::ACC_W:0] sum;
  llf_pkg::acc_t                  sum_sat;
  llf_pkg::result_t               res_sat;
  logic [llf_pkg::OUT_CH_W-1:0]   n_out;

  logic [llf_pkg::ROW_W-1:0]      out_ch_r;
  llf_pkg::result_t               out_value_r;
  logic                           out_last_r;

  logic          take;
  logic          w_we;
  logic          b_we;
  logic [AW-1:0] w_waddr;
  logic [AW-1:0] w_raddr;

  assign take    = (state_r == llf_pkg::ST_IDLE) && q_valid;
  assign q_pop   = take;
  assign w_we    = take && (q_data.kind == llf_pkg::CMD_WEIGHT);
  assign b_we    = take && (q_data.kind == llf_pkg::CMD_BIAS);
  assign w_waddr = {q_data.row[OW-1:0], q_data.col[IW-1:0]};
  assign w_raddr = {o_r, cmd_r.col[IW-1:0]};

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[w_waddr] <= q_data.value;
    end
    w_q_r <= w_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[q_data.row[OW-1:0]] <= q_data.value;
    end
    b_q_r <= b_mem[o_r];
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      a_mem[s2_ch_r] <= sum_sat;
    end
    a_q_r <= a_mem[o_r];
  end

  assign sum = (llf_pkg::ACC_W + 1)'(base_r) + (llf_pkg::ACC_W + 1)'(prod_r);

  always_comb begin
    if (sum[llf_pkg::ACC_W] != sum[llf_pkg::ACC_W-1]) begin
      sum_sat = sum[llf_pkg::ACC_W] ? {1'b1, {(llf_pkg::ACC_W-1){1'b0}}}
                                    : {1'b0, {(llf_pkg::ACC_W-1){1'b1}}};
    end else begin
      sum_sat = sum[llf_pkg::ACC_W-1:0];
    end
  end

  always_comb begin
    if ((a_q_r[llf_pkg::ACC_W-1:llf_pkg::RESULT_W-1] == '0) ||
        (a_q_r[llf_pkg::ACC_W-1:llf_pkg::RESULT_W-1] == '1)) begin
      res_sat = a_q_r[llf_pkg::RESULT_W-1:0];
    end else begin
      res_sat = a_q_r[llf_pkg::ACC_W-1] ? {1'b1, {(llf_pkg::RESULT_W-1){1'b0}}}
                                        : {1'b0, {(llf_pkg::RESULT_W-1){1'b1}}};
    end
  end

  assign n_out = (cfg.out_channels == '0) ? llf_pkg::OUT_CH_W'(1) :
                 (cfg.out_channels > llf_pkg::OUT_CH_W'(MAX_OUT_CHANNELS)) ?
                 llf_pkg::OUT_CH_W'(MAX_OUT_CHANNELS) : cfg.out_channels;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      llf_pkg::ST_IDLE: begin
        if (take && (q_data.kind == llf_pkg::CMD_DATA)) begin
          state_nxt = llf_pkg::ST_SWEEP;
        end
      end
      llf_pkg::ST_SWEEP: begin
        if (o_r == OW'(MAX_OUT_CHANNELS - 1)) begin
          state_nxt = llf_pkg::ST_DRAIN;
        end
      end
      llf_pkg::ST_DRAIN: begin
        if (!s1_v_r && !s2_v_r) begin
          state_nxt = cmd_r.last ? llf_pkg::ST_EMIT_RD : llf_pkg::ST_IDLE;
        end
      end
      llf_pkg::ST_EMIT_RD: begin
        state_nxt = llf_pkg::ST_EMIT_LD;
      end
      llf_pkg::ST_EMIT_LD: begin
        state_nxt = llf_pkg::ST_EMIT_OUT;
      end
      llf_pkg::ST_EMIT_OUT: begin
        if (out_item.ready) begin
          state_nxt = out_last_r ? llf_pkg::ST_IDLE : llf_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = llf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= llf_pkg::ST_IDLE;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      o_r     <= '0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= (state_r == llf_pkg::ST_SWEEP);
      s2_v_r  <= s1_v_r;
      case (state_r)
        llf_pkg::ST_IDLE: begin
          o_r <= '0;
        end
        llf_pkg::ST_SWEEP: begin
          if (o_r != OW'(MAX_OUT_CHANNELS - 1)) begin
            o_r <= o_r + 1'b1;
          end
        end
        llf_pkg::ST_DRAIN: begin
          if (!s1_v_r && !s2_v_r) begin
            o_r <= '0;
          end
        end
        llf_pkg::ST_EMIT_OUT: begin
          if (out_item.ready && !out_last_r) begin
            o_r <= o_r + 1'b1;
          end
        end
        default: begin
          o_r <= o_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take && (q_data.kind == llf_pkg::CMD_DATA)) begin
      cmd_r <= q_data;
    end
    s1_ch_r <= o_r;
    s2_ch_r <= s1_ch_r;
    prod_r  <= cmd_r.value * w_q_r;
    if (!cmd_r.first) begin
      base_r <= a_q_r;
    end else if (cfg.use_bias) begin
      base_r <= {{(llf_pkg::ACC_W - llf_pkg::VALUE_W - 8){b_q_r[llf_pkg::VALUE_W-1]}},
                 b_q_r, 8'h00};
    end else begin
      base_r <= '0;
    end
    if (state_r == llf_pkg::ST_EMIT_LD) begin
      out_ch_r    <= llf_pkg::row_t'(o_r);
      out_value_r <= res_sat;
      out_last_r  <= (llf_pkg::OUT_CH_W'(o_r) == (n_out - llf_pkg::OUT_CH_W'(1)));
    end
  end

  assign out_item.valid        = (state_r == llf_pkg::ST_EMIT_OUT);
  assign out_item.channel      = out_ch_r;
  assign out_item.result_value = out_value_r;
  assign out_item.last_of_row  = out_last_r;

endmodule

// File: design/linear_layer_forward_core.sv
// Weight and bias loads: retire one per cycle from the command queue while the back end is idle.
// Data element: taken from the queue, then one channel per cycle through the shared
// multiply-accumulate unit, then the MAC pipeline drains.
// Row end: each result goes through accumulator read, saturate, output handshake.
// Input takes items while the 4-entry queue has room, also during output stalls.
// rst_n (synchronous) clears control and config; weight, bias, sums keep no reset.
module linear_layer_forward_core #(
  parameter int MAX_IN_CHANNELS  = 256,
  parameter int MAX_OUT_CHANNELS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  llf_in_if.sink                             in_item,
  llf_out_if.source                          out_item,
  input  logic                               cfg_we,
  input  logic [llf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [llf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  llf_pkg::cfg_t cfg_r;
  llf_pkg::cmd_t push_data;
  llf_pkg::cmd_t q_data;
  logic          push;
  logic          queue_full;
  logic          q_valid;
  logic          q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_channels  <= llf_pkg::IN_CHANNELS_RST;
      cfg_r.out_channels <= llf_pkg::OUT_CHANNELS_RST;
      cfg_r.use_bias     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        llf_pkg::CFG_IN_CHANNELS: begin
          cfg_r.in_channels <= cfg_wdata[llf_pkg::IN_CH_W-1:0];
        end
        llf_pkg::CFG_OUT_CHANNELS: begin
          cfg_r.out_channels <= cfg_wdata[llf_pkg::OUT_CH_W-1:0];
        end
        llf_pkg::CFG_USE_BIAS: begin
          cfg_r.use_bias <= cfg_wdata[0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  llf_front #(
    .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
    .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_item    (in_item),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  llf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .q_valid   (q_valid),
    .pop       (q_pop),
    .q_data    (q_data)
  );

  llf_back #(
    .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
    .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_item (out_item)
  );

endmodule
